// ----- rtl/bel_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the button edge latch.
// Has no dependencies; every other file of the block uses it.

package bel_pkg;

    localparam int TIME_W  = 64;
    localparam int SET_W   = 32;
    localparam int ACT_W   = 6;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ACT_W-1:0]  action;
        logic              pressed;
        logic [TIME_W-1:0] edge_time;
        logic [TIME_W-1:0] now_time;
        logic [SET_W-1:0]  level_bits;
        logic              focused;
    } t_item;

    typedef struct packed {
        logic [SET_W-1:0]  buttons;
        logic [TIME_W-1:0] latency;
        logic              latency_valid;
        logic              in_range;
    } t_result;

endpackage

// ----- rtl/bel_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the button edge latch: request, result and configuration.
// Depends on bel_pkg for field widths.

interface bel_in_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [bel_pkg::ACT_W-1:0]  action;
    logic                       pressed;
    logic [bel_pkg::TIME_W-1:0] edge_time;
    logic [bel_pkg::TIME_W-1:0] now_time;
    logic [bel_pkg::SET_W-1:0]  level_bits;
    logic                       focused;

    modport source (output valid, command, action, pressed, edge_time, now_time,
                    level_bits, focused, input ready);
    modport sink (input valid, command, action, pressed, edge_time, now_time,
                  level_bits, focused, output ready);
endinterface

interface bel_out_if;
    logic                       valid;
    logic                       ready;
    logic [bel_pkg::SET_W-1:0]  buttons;
    logic [bel_pkg::TIME_W-1:0] latency;
    logic                       latency_valid;
    logic [bel_pkg::TIME_W-1:0] press_time_out;
    logic [bel_pkg::TIME_W-1:0] release_time_out;

    modport source (output valid, buttons, latency, latency_valid, press_time_out,
                    release_time_out, input ready);
    modport sink (input valid, buttons, latency, latency_valid, press_time_out,
                  release_time_out, output ready);
endinterface

interface bel_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [bel_pkg::SET_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- rtl/button_edge_latch_with_focus_gate_unit.sv -----
`timescale 1ns / 1ps
// Top level of the button edge latch with focus gate.
// Uses bel_pkg, the channel interfaces, bel_seq and bel_time_ram.

// Requests are handled one at a time. An edge request passes from acceptance
// through execute with memory write, memory read and loading of the output
// register before the next request is accepted. A tick request runs the
// sweep that visits every action and writes one entry a cycle through the
// single write port of each timestamp memory, then memory read and output
// load. A result that is not taken holds the block in its final step until
// the output register frees. The gameplay mask is taken on every cycle of the
// configuration channel and must only be written while the block is idle.

module button_edge_latch_with_focus_gate_unit #(
    parameter int ACTION_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bel_in_if.sink      i_in,
    bel_out_if.source   o_out,
    bel_cfg_if.sink     i_cfg
);
    localparam int AW = (ACTION_COUNT > 1) ? $clog2(ACTION_COUNT) : 1;

    logic [bel_pkg::SET_W-1:0]  r_gameplay_mask;
    bel_pkg::t_item             item;
    bel_pkg::t_result           res;
    logic                       res_load;
    logic                       out_free;
    logic                       press_we, rel_we, re;
    logic [AW-1:0]              waddr, raddr;
    logic [bel_pkg::TIME_W-1:0] wdata, press_rdata, rel_rdata;

    logic                       r_out_vld;
    logic [bel_pkg::SET_W-1:0]  r_buttons;
    logic [bel_pkg::TIME_W-1:0] r_latency;
    logic                       r_latency_valid;
    logic [bel_pkg::TIME_W-1:0] r_press_time;
    logic [bel_pkg::TIME_W-1:0] r_release_time;

    assign item.command    = i_in.command;
    assign item.action     = i_in.action;
    assign item.pressed    = i_in.pressed;
    assign item.edge_time  = i_in.edge_time;
    assign item.now_time   = i_in.now_time;
    assign item.level_bits = i_in.level_bits;
    assign item.focused    = i_in.focused;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gameplay_mask <= '0;
        end else if (i_cfg.valid) begin
            r_gameplay_mask <= i_cfg.data;
        end
    end

    bel_seq #(
        .ACTION_COUNT(ACTION_COUNT)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (i_in.ready),
        .i_item         (item),
        .i_gameplay_mask(r_gameplay_mask),
        .i_out_free     (out_free),
        .o_press_we     (press_we),
        .o_rel_we       (rel_we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_re           (re),
        .o_raddr        (raddr),
        .o_res_load     (res_load),
        .o_res          (res)
    );

    bel_time_ram #(
        .DEPTH(ACTION_COUNT)
    ) u_press_ram (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (press_we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(press_rdata)
    );

    bel_time_ram #(
        .DEPTH(ACTION_COUNT)
    ) u_release_ram (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (rel_we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rel_rdata)
    );

    assign out_free = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_buttons       <= res.buttons;
            r_latency       <= res.latency;
            r_latency_valid <= res.latency_valid;
            r_press_time    <= res.in_range ? press_rdata : '0;
            r_release_time  <= res.in_range ? rel_rdata : '0;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.buttons          = r_buttons;
    assign o_out.latency          = r_latency;
    assign o_out.latency_valid    = r_latency_valid;
    assign o_out.press_time_out   = r_press_time;
    assign o_out.release_time_out = r_release_time;

endmodule

// ----- rtl/bel_time_ram.sv -----
`timescale 1ns / 1ps
// Timestamp memory with one write port and one registered read port.
// Per-entry valid bits make never-written entries read as zero. Uses bel_pkg.

module bel_time_ram #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [bel_pkg::TIME_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [bel_pkg::TIME_W-1:0] o_rdata
);
    logic [bel_pkg::TIME_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    logic [bel_pkg::TIME_W-1:0] r_rdata;
    logic                       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

// ----- rtl/bel_seq.sv -----
`timescale 1ns / 1ps
// Sequencer of the button edge latch: pressed set, edge handling and tick sweep.
// Drives both timestamp memories. Uses bel_pkg.

module bel_seq #(
    parameter int ACTION_COUNT = 32,
    localparam int AW = (ACTION_COUNT > 1) ? $clog2(ACTION_COUNT) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  bel_pkg::t_item             i_item,
    input  logic [bel_pkg::SET_W-1:0]  i_gameplay_mask,
    input  logic                       i_out_free,
    output logic                       o_press_we,
    output logic                       o_rel_we,
    output logic [AW-1:0]              o_waddr,
    output logic [bel_pkg::TIME_W-1:0] o_wdata,
    output logic                       o_re,
    output logic [AW-1:0]              o_raddr,
    output logic                       o_res_load,
    output bel_pkg::t_result           o_res
);
    localparam int N  = ACTION_COUNT;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EDGE  = 5'b00010,
        S_SWEEP = 5'b00100,
        S_READ  = 5'b01000,
        S_LOAD  = 5'b10000
    } t_state;

    t_state                      r_state, n_state;
    logic                        r_pressed, n_pressed;
    logic                        r_focused, n_focused;
    logic [bel_pkg::ACT_W-1:0]   r_action, n_action;
    logic [bel_pkg::TIME_W-1:0]  r_edge_time, n_edge_time;
    logic [bel_pkg::TIME_W-1:0]  r_now, n_now;
    logic [N-1:0]                r_level, n_level;
    logic [N-1:0]                r_diff, n_diff;
    logic [N-1:0]                r_set, n_set;
    logic [AW-1:0]               r_idx, n_idx;
    logic [bel_pkg::TIME_W-1:0]  r_lat, n_lat;
    logic                        r_lat_vld, n_lat_vld;

    logic [N-1:0]  lvl_gated;
    logic          in_range;
    logic          edge_ok;
    logic [AW-1:0] addr_edge;

    assign lvl_gated = i_item.level_bits[N-1:0]
                     & (i_item.focused ? {N{1'b1}} : ~i_gameplay_mask[N-1:0]);
    assign in_range  = r_action < bel_pkg::ACT_W'(ACTION_COUNT);
    assign edge_ok   = in_range && (r_focused || !i_gameplay_mask[r_action[4:0]]);
    assign addr_edge = r_action[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_pressed   = r_pressed;
        n_focused   = r_focused;
        n_action    = r_action;
        n_edge_time = r_edge_time;
        n_now       = r_now;
        n_level     = r_level;
        n_diff      = r_diff;
        n_set       = r_set;
        n_idx       = r_idx;
        n_lat       = r_lat;
        n_lat_vld   = r_lat_vld;
        o_press_we  = 1'b0;
        o_rel_we    = 1'b0;
        o_waddr     = addr_edge;
        o_wdata     = r_edge_time;
        o_re        = 1'b0;
        o_raddr     = addr_edge;
        o_res_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pressed   = i_item.pressed;
                    n_focused   = i_item.focused;
                    n_action    = i_item.action;
                    n_edge_time = i_item.edge_time;
                    n_now       = i_item.now_time;
                    n_idx       = '0;
                    n_lat       = '0;
                    n_lat_vld   = 1'b0;
                    if (i_item.command == bel_pkg::CMD_TICK) begin
                        n_diff  = r_set ^ lvl_gated;
                        n_level = lvl_gated;
                        n_set   = lvl_gated;
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_EDGE;
                    end
                end
            end
            S_EDGE: begin
                if (edge_ok) begin
                    if (r_pressed) begin
                        o_press_we       = 1'b1;
                        n_set[addr_edge] = 1'b1;
                        n_lat            = (r_now > r_edge_time) ? r_now - r_edge_time : '0;
                        n_lat_vld        = 1'b1;
                    end else begin
                        o_rel_we         = 1'b1;
                        n_set[addr_edge] = 1'b0;
                    end
                end
                n_state = S_READ;
            end
            S_SWEEP: begin
                o_waddr    = r_idx;
                o_wdata    = r_now;
                o_press_we = r_diff[r_idx] & r_level[r_idx];
                o_rel_we   = r_diff[r_idx] & ~r_level[r_idx];
                if (r_idx == AW'(ACTION_COUNT - 1)) begin
                    n_state = S_READ;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_READ: begin
                o_re    = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_set     <= '0;
            r_idx     <= '0;
            r_lat_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_set     <= n_set;
            r_idx     <= n_idx;
            r_lat_vld <= n_lat_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pressed   <= n_pressed;
        r_focused   <= n_focused;
        r_action    <= n_action;
        r_edge_time <= n_edge_time;
        r_now       <= n_now;
        r_level     <= n_level;
        r_diff      <= n_diff;
        r_lat       <= n_lat;
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_res.buttons       = bel_pkg::SET_W'(r_set);
    assign o_res.latency       = r_lat;
    assign o_res.latency_valid = r_lat_vld;
    assign o_res.in_range      = in_range;

endmodule

// ----- rtl/bel_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the button edge latch, attached to the top level by bind.
// Depends on bel_pkg and on the top level's ports.

module bel_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [bel_pkg::SET_W-1:0]  i_buttons,
    input logic [bel_pkg::TIME_W-1:0] i_latency,
    input logic                       i_latency_valid
);

    // The block works on one request at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while another is in progress");

    a_latency_only_on_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_latency_valid) |-> (i_latency == '0))
        else $error("nonzero latency without a press sample");

    a_press_sets_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_latency_valid) |-> (i_buttons != '0))
        else $error("press sample with an empty pressed set");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before it was taken");

endmodule

bind button_edge_latch_with_focus_gate_unit bel_checker u_bel_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_buttons      (o_out.buttons),
    .i_latency      (o_out.latency),
    .i_latency_valid(o_out.latency_valid)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the button edge latch with focus gate.
// Depends on bel_pkg, the channel interfaces and the RTL top level.

module tb_top;

    localparam int ACTIONS     = 32;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [bel_pkg::SET_W-1:0]  buttons;
        logic [bel_pkg::TIME_W-1:0] latency;
        logic                       latency_valid;
        logic [bel_pkg::TIME_W-1:0] press_time;
        logic [bel_pkg::TIME_W-1:0] release_time;
    } t_latch_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bel_in_if  req_ch ();
    bel_out_if res_ch ();
    bel_cfg_if cfg_ch ();

    button_edge_latch_with_focus_gate_unit #(
        .ACTION_COUNT(ACTIONS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (res_ch),
        .i_cfg  (cfg_ch)
    );

    logic [bel_pkg::SET_W-1:0]  gameplay_mask = '0;
    logic [bel_pkg::SET_W-1:0]  held_buttons  = '0;
    logic [bel_pkg::TIME_W-1:0] press_stamp   [ACTIONS];
    logic [bel_pkg::TIME_W-1:0] release_stamp [ACTIONS];
    t_latch_result              pending_results[$];
    int                         issued   = 0;
    int                         retired  = 0;
    int                         failures = 0;
    int                         quiet_cycles = 0;
    bit                         pacing_on = 1'b1;
    logic [bel_pkg::TIME_W-1:0] clock_ns = '0;

    initial begin
        for (int a = 0; a < ACTIONS; a++) begin
            press_stamp[a]   = '0;
            release_stamp[a] = '0;
        end
    end

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_latch_result predict_latch(input bel_pkg::t_item req);
        t_latch_result             r;
        logic [bel_pkg::SET_W-1:0] level;
        logic [63:0]               active;
        logic                      in_range;
        r        = '0;
        in_range = req.action < ACTIONS;
        if (req.command == bel_pkg::CMD_EDGE) begin
            if (in_range && (req.focused || !gameplay_mask[req.action])) begin
                if (req.pressed) begin
                    held_buttons[req.action] = 1'b1;
                    press_stamp[req.action]  = req.edge_time;
                    r.latency = (req.now_time > req.edge_time) ?
                                req.now_time - req.edge_time : '0;
                    r.latency_valid = 1'b1;
                end else begin
                    held_buttons[req.action]  = 1'b0;
                    release_stamp[req.action] = req.edge_time;
                end
            end
        end else begin
            active = (64'd1 << ACTIONS) - 64'd1;
            level  = req.level_bits & active[bel_pkg::SET_W-1:0];
            if (!req.focused) begin
                level = level & ~gameplay_mask;
            end
            for (int a = 0; a < ACTIONS; a++) begin
                if (held_buttons[a] != level[a]) begin
                    if (level[a]) begin
                        press_stamp[a] = req.now_time;
                    end else begin
                        release_stamp[a] = req.now_time;
                    end
                    held_buttons[a] = level[a];
                end
            end
        end
        r.buttons = held_buttons;
        if (in_range) begin
            r.press_time   = press_stamp[req.action];
            r.release_time = release_stamp[req.action];
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        bel_pkg::t_item seen;
        t_latch_result  want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                gameplay_mask = cfg_ch.data;
            end
            if (req_ch.valid && req_ch.ready) begin
                seen.command    = req_ch.command;
                seen.action     = req_ch.action;
                seen.pressed    = req_ch.pressed;
                seen.edge_time  = req_ch.edge_time;
                seen.now_time   = req_ch.now_time;
                seen.level_bits = req_ch.level_bits;
                seen.focused    = req_ch.focused;
                pending_results.push_back(predict_latch(seen));
                issued++;
            end
            if (res_ch.valid && res_ch.ready) begin
                retired++;
                if (pending_results.size() == 0) begin
                    failures++;
                    $display("%0t: result with no request outstanding, %s %h",
                             $time, "expected none, actual buttons", res_ch.buttons);
                end else begin
                    want = pending_results.pop_front();
                    check_field("buttons", 64'(want.buttons), 64'(res_ch.buttons));
                    check_field("latency", want.latency, res_ch.latency);
                    check_field("latency_valid", 64'(want.latency_valid),
                                64'(res_ch.latency_valid));
                    check_field("press_time_out", want.press_time, res_ch.press_time_out);
                    check_field("release_time_out", want.release_time,
                                res_ch.release_time_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = pacing_on ? int'($urandom_range(0, 15)) : 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    task automatic send_request(input bel_pkg::t_item req);
        int gap;
        gap = pacing_on ? int'($urandom_range(0, 15)) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= req.command;
        req_ch.action     <= req.action;
        req_ch.pressed    <= req.pressed;
        req_ch.edge_time  <= req.edge_time;
        req_ch.now_time   <= req.now_time;
        req_ch.level_bits <= req.level_bits;
        req_ch.focused    <= req.focused;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (issued != retired);
        @(posedge i_clk);
    endtask

    task automatic write_gameplay_mask(input logic [bel_pkg::SET_W-1:0] value);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic bel_pkg::t_item edge_request(input logic [bel_pkg::ACT_W-1:0] act,
                                                    input logic press,
                                                    input logic [bel_pkg::TIME_W-1:0] at_ns,
                                                    input logic [bel_pkg::TIME_W-1:0] now_ns,
                                                    input logic focus);
        bel_pkg::t_item r;
        r           = '0;
        r.command   = bel_pkg::CMD_EDGE;
        r.action    = act;
        r.pressed   = press;
        r.edge_time = at_ns;
        r.now_time  = now_ns;
        r.focused   = focus;
        return r;
    endfunction

    function automatic bel_pkg::t_item tick_request(input logic [bel_pkg::ACT_W-1:0] act,
                                                    input logic [bel_pkg::SET_W-1:0] levels,
                                                    input logic [bel_pkg::TIME_W-1:0] now_ns,
                                                    input logic focus);
        bel_pkg::t_item r;
        r            = '0;
        r.command    = bel_pkg::CMD_TICK;
        r.action     = act;
        r.level_bits = levels;
        r.now_time   = now_ns;
        r.focused    = focus;
        return r;
    endfunction

    function automatic bel_pkg::t_item random_request();
        bel_pkg::t_item r;
        r         = '0;
        r.command = ($urandom_range(0, 99) < 30) ? bel_pkg::CMD_TICK : bel_pkg::CMD_EDGE;
        r.action  = ($urandom_range(0, 9) == 0) ?
                    bel_pkg::ACT_W'($urandom_range(32, 63)) :
                    bel_pkg::ACT_W'($urandom_range(0, 31));
        r.pressed = 1'($urandom_range(0, 1));
        r.focused = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 15) == 0) begin
            r.edge_time = {$urandom, $urandom};
            r.now_time  = {$urandom, $urandom};
        end else begin
            clock_ns    = clock_ns + 64'($urandom_range(1, 5000000));
            r.now_time  = clock_ns;
            r.edge_time = clock_ns - 64'($urandom_range(0, 20000000));
            if ($urandom_range(0, 7) == 0) begin
                r.edge_time = clock_ns + 64'($urandom_range(1, 1000));
            end
        end
        case ($urandom_range(0, 3))
            0: r.level_bits = $urandom;
            1: r.level_bits = held_buttons ^ (32'd1 << $urandom_range(0, 31));
            2: r.level_bits = held_buttons;
            default: r.level_bits = $urandom_range(0, 1) ? '1 : '0;
        endcase
        return r;
    endfunction

    task automatic test_reset_state();
        send_request(tick_request(6'd5, '0, 64'd10, 1'b1));
        send_request(edge_request(6'd31, 1'b0, 64'd20, 64'd20, 1'b1));
    endtask

    task automatic test_edge_extremes();
        send_request(edge_request(6'd0, 1'b1, '0, '1, 1'b1));
        send_request(edge_request(6'd31, 1'b1, '1, '0, 1'b1));
        send_request(edge_request(6'd7, 1'b1, 64'd123, 64'd123, 1'b1));
        send_request(edge_request(6'd0, 1'b0, '1, '0, 1'b1));
        send_request(edge_request(6'd31, 1'b0, '0, '1, 1'b0));
        send_request(edge_request(6'd32, 1'b1, 64'd5, 64'd50, 1'b1));
        send_request(edge_request(6'd63, 1'b0, '1, '1, 1'b1));
    endtask

    task automatic test_tick_reconcile();
        send_request(tick_request(6'd3, '1, 64'd1000, 1'b1));
        send_request(tick_request(6'd31, '0, '1, 1'b1));
        send_request(tick_request(6'd63, 32'h5A5A_A5A5, 64'd2000, 1'b1));
        send_request(tick_request(6'd1, 32'hA5A5_5A5A, 64'd3000, 1'b0));
    endtask

    task automatic test_focus_gate();
        write_gameplay_mask(32'hFFFF_0000);
        send_request(edge_request(6'd20, 1'b1, 64'd100, 64'd150, 1'b0));
        send_request(edge_request(6'd4, 1'b1, 64'd110, 64'd150, 1'b0));
        send_request(edge_request(6'd20, 1'b1, 64'd120, 64'd150, 1'b1));
        send_request(edge_request(6'd20, 1'b0, 64'd130, 64'd150, 1'b0));
        send_request(tick_request(6'd20, '1, 64'd200, 1'b0));
        send_request(tick_request(6'd20, '1, 64'd300, 1'b1));
        write_gameplay_mask('1);
        send_request(edge_request(6'd0, 1'b0, 64'd400, 64'd410, 1'b0));
        send_request(tick_request(6'd9, '1, 64'd500, 1'b0));
    endtask

    task automatic test_random_traffic(input logic [bel_pkg::SET_W-1:0] mask,
                                       input int count);
        write_gameplay_mask(mask);
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                pacing_on = ($urandom_range(0, 2) != 0);
            end
            send_request(random_request());
        end
        pacing_on = 1'b1;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.command    <= bel_pkg::CMD_EDGE;
        req_ch.action     <= '0;
        req_ch.pressed    <= 1'b0;
        req_ch.edge_time  <= '0;
        req_ch.now_time   <= '0;
        req_ch.level_bits <= '0;
        req_ch.focused    <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_edge_extremes();
        test_tick_reconcile();
        test_focus_gate();
        test_random_traffic('0, 340);
        test_random_traffic('1, 340);
        test_random_traffic($urandom, 340);
        test_random_traffic(32'h5555_AAAA, 340);
        test_random_traffic($urandom, 340);

        wait_idle();
        repeat (ACTIONS + 3) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            failures++;
            $display("%0t: requests left without a result, expected 0, actual %0d",
                     $time, pending_results.size());
        end
        if (failures == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bel_pkg.sv
rtl/bel_if.sv
rtl/bel_time_ram.sv
rtl/bel_seq.sv
rtl/button_edge_latch_with_focus_gate_unit.sv
rtl/bel_checker.sv
tb/tb_top.sv
